@@ rtl/rqdt_pkg.sv @@
`default_nettype none

package rqdt_pkg;

	localparam int TOTAL_W = 22;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3F_FFFF;

	localparam logic [1:0] OP_CLEAR    = 2'd0;
	localparam logic [1:0] OP_LOAD     = 2'd1;
	localparam logic [1:0] OP_REQUEST  = 2'd2;
	localparam logic [1:0] OP_COMPLETE = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_NONE  = 2'd2;
	localparam logic [1:0] STAT_MIXED = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] gen_id;
		logic [15:0] batch_id;
		logic [15:0] run_count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         slot_index;
		logic [15:0]        out_gen;
		logic [15:0]        out_batch;
		logic [15:0]        granted_runs;
		logic [TOTAL_W-1:0] runs_left_total;
	} rsp_t;

	typedef struct packed {
		logic [15:0] gen;
		logic [15:0] batch;
		logic [15:0] owed;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PTR,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ rtl/rqdt_slot_ram.sv @@
`default_nettype none

module rqdt_slot_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire rqdt_pkg::slot_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output rqdt_pkg::slot_t      rdata
);
	import rqdt_pkg::*;

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/run_quota_dispatch_table.sv @@
`default_nettype none

// Run quota dispatch table.
// Command channel (cmd_valid/cmd_ready/cmd) takes one operation at a time:
// clear, load, request or complete. Each command gives exactly one response
// on rsp_valid/rsp_ready/rsp, carrying the status, the grant and the total
// of runs still owed after the command.
// Clear, load and any command on an empty table go straight to the done
// state. A request first reads the slot at the pointer; if that slot owes
// runs, it goes on to the done state, otherwise it scans the slot RAM from
// slot 0, one slot per cycle, and a complete scans the same way. A scan
// reads no further than the entry count, which is at most SLOTS. The scan
// rate is set by the single read port of the slot RAM, whose read data is
// registered.
// cmd_ready is high only between commands; one command is in flight at once.
// A finished response waits in an internal register while rsp_ready is low,
// and the next command is already taken during that wait.
// Reset empties the table, zeroes pointer and total, and drops rsp_valid.
// Slot contents are not cleared; only slots below the entry count are used.
module run_quota_dispatch_table #(
	parameter int SLOTS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire rqdt_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output rqdt_pkg::rsp_t      rsp
);
	import rqdt_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	state_t             state_q, state_d;
	cmd_t               cmd_q, cmd_d;
	logic [CW-1:0]      count_q, count_d;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic [15:0]        tgen_q, tgen_d;
	logic               tgen_vld_q, tgen_vld_d;
	logic [CW-1:0]      scan_addr_q, scan_addr_d;
	logic [AW-1:0]      rd_idx_s1, rd_idx_d;
	rsp_t               res_q, res_d;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_valid_q, rsp_valid_d;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	slot_t              ram_wdata;
	logic [AW-1:0]      ram_raddr;
	slot_t              ram_rdata;

	logic [TOTAL_W:0]   load_sum;
	logic [15:0]        take;
	logic               hit;
	logic [CW-1:0]      last_idx;

	rqdt_slot_ram #(
		.DEPTH(SLOTS),
		.AW   (AW)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign load_sum = {1'b0, total_q} + (TOTAL_W + 1)'(cmd.run_count);
	assign take     = (cmd_q.run_count > ram_rdata.owed) ? ram_rdata.owed : cmd_q.run_count;
	assign last_idx = count_q - CW'(1);
	assign hit      = (cmd_q.operation == OP_REQUEST) ? (ram_rdata.owed != 16'd0) :
	                  (ram_rdata.gen == cmd_q.gen_id && ram_rdata.batch == cmd_q.batch_id);

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		count_d     = count_q;
		ptr_d       = ptr_q;
		total_d     = total_q;
		tgen_d      = tgen_q;
		tgen_vld_d  = tgen_vld_q;
		scan_addr_d = scan_addr_q;
		rd_idx_d    = rd_idx_s1;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q;
		ram_we      = 1'b0;
		ram_waddr   = count_q[AW-1:0];
		ram_wdata   = '{gen: cmd.gen_id, batch: cmd.batch_id, owed: cmd.run_count};
		ram_raddr   = ptr_q;

		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d = cmd;
					res_d = '0;
					case (cmd.operation)
						OP_CLEAR: begin
							count_d    = '0;
							ptr_d      = '0;
							total_d    = '0;
							tgen_vld_d = 1'b0;
							state_d    = ST_DONE;
						end
						OP_LOAD: begin
							state_d = ST_DONE;
							if (tgen_vld_q && cmd.gen_id != tgen_q) begin
								res_d.status = STAT_MIXED;
							end else if (count_q == CW'(SLOTS)) begin
								res_d.status = STAT_FULL;
							end else begin
								if (!tgen_vld_q) begin
									tgen_d     = cmd.gen_id;
									tgen_vld_d = 1'b1;
								end
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
								total_d = load_sum[TOTAL_W] ? TOTAL_MAX : load_sum[TOTAL_W-1:0];
							end
						end
						OP_REQUEST: begin
							if (count_q == '0) begin
								res_d.status = STAT_NONE;
								state_d      = ST_DONE;
							end else begin
								state_d = ST_PTR;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_d.status = STAT_NONE;
								state_d      = ST_DONE;
							end else begin
								ram_raddr   = '0;
								rd_idx_d    = '0;
								scan_addr_d = CW'(1);
								state_d     = ST_SCAN;
							end
						end
					endcase
				end
			end

			ST_PTR: begin
				if (ram_rdata.owed != 16'd0) begin
					res_d.slot_index   = 6'(ptr_q);
					res_d.out_gen      = ram_rdata.gen;
					res_d.out_batch    = ram_rdata.batch;
					res_d.granted_runs = cmd_q.run_count;
					ptr_d   = (CW'(ptr_q) == last_idx) ? '0 : ptr_q + AW'(1);
					state_d = ST_DONE;
				end else begin
					// fall back to the first slot that owes runs
					ram_raddr   = '0;
					rd_idx_d    = '0;
					scan_addr_d = CW'(1);
					state_d     = ST_SCAN;
				end
			end

			ST_SCAN: begin
				// keep one read in flight ahead of the slot under test
				ram_raddr   = scan_addr_q[AW-1:0];
				rd_idx_d    = scan_addr_q[AW-1:0];
				scan_addr_d = scan_addr_q + CW'(1);
				if (hit) begin
					state_d = ST_DONE;
					if (cmd_q.operation == OP_REQUEST) begin
						res_d.slot_index   = 6'(rd_idx_s1);
						res_d.out_gen      = ram_rdata.gen;
						res_d.out_batch    = ram_rdata.batch;
						res_d.granted_runs = cmd_q.run_count;
						ptr_d = (CW'(ptr_q) == last_idx) ? '0 : ptr_q + AW'(1);
					end else begin
						ram_we    = 1'b1;
						ram_waddr = rd_idx_s1;
						ram_wdata = '{gen: ram_rdata.gen, batch: ram_rdata.batch,
						              owed: ram_rdata.owed - take};
						total_d   = (total_q > TOTAL_W'(take)) ?
						            total_q - TOTAL_W'(take) : '0;
					end
				end else if (CW'(rd_idx_s1) == last_idx) begin
					res_d.status = STAT_NONE;
					state_d      = ST_DONE;
				end
			end

			ST_DONE: begin
				// hold until the output register is free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d                 = res_q;
					rsp_d.runs_left_total = total_q;
					rsp_valid_d           = 1'b1;
					state_d               = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			total_q     <= '0;
			tgen_q      <= '0;
			tgen_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ptr_q       <= ptr_d;
			total_q     <= total_d;
			tgen_q      <= tgen_d;
			tgen_vld_q  <= tgen_vld_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		scan_addr_q <= scan_addr_d;
		rd_idx_s1   <= rd_idx_d;
		res_q       <= res_d;
		rsp_q       <= rsp_d;
	end

`ifndef SYNTH
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(ptr_q) < count_q) || (ptr_q == '0))
		else $error("round-robin pointer beyond entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("entry count beyond table size");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside done state");

	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q != ST_IDLE))
		else $error("command transfer did not start processing");

	a_grant_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != STAT_OK) |-> (rsp_q.granted_runs == 16'd0))
		else $error("runs granted on a failed command");
`endif

endmodule

`default_nettype wire

@@ test/run_quota_dispatch_table_tb.sv @@
`timescale 1ns / 1ps

module run_quota_dispatch_table_tb;
	import rqdt_pkg::*;

	localparam int SLOT_COUNT = 64;
	localparam int ITEM_TARGET = 1800;
	localparam int WATCHDOG = 3000;
	localparam int DIRECTED_ROWS = 26;
	localparam rsp_t FREE = '0;

	typedef struct packed {
		cmd_t c;
		logic pinned;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow of the dispatch table
	logic [15:0] tbl_gen [SLOT_COUNT];
	logic [15:0] tbl_batch [SLOT_COUNT];
	logic [15:0] tbl_owed [SLOT_COUNT];
	int tbl_count = 0;
	int rr_ptr = 0;
	int owed_sum = 0;
	logic [15:0] lead_gen = '0;
	logic lead_set = 1'b0;

	rsp_t rsp_due [$];
	rsp_t predicted;
	rsp_t want_rsp;
	rsp_t pinned_rsp = '0;
	logic pin_next = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int rsp_seen = 0;
	int n_full = 0;
	int n_mixed = 0;
	int n_none = 0;
	int idle_cycles = 0;
	int snd_idle_pct = 21;
	int rsp_idle_pct = 59;

	// Directed rows: pinned rows carry a typed-in response, the rest use the predictor.
	plan_row_t plan [DIRECTED_ROWS] = '{
		{OP_REQUEST,  16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_NONE,  54'd0, 22'h000000},
		{OP_COMPLETE, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_NONE,  54'd0, 22'h000000},
		{OP_LOAD,     16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, STAT_OK,    54'd0, 22'h00FFFF},
		{OP_LOAD,     16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, STAT_MIXED, 54'd0, 22'h00FFFF},
		{OP_LOAD,     16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, STAT_OK,    54'd0, 22'h00FFFF},
		{OP_LOAD,     16'hFFFF, 16'h0001, 16'h0005, 1'b0, FREE},
		{OP_REQUEST,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, FREE},
		{OP_REQUEST,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, FREE},
		{OP_REQUEST,  16'h0000, 16'h0000, 16'h0001, 1'b0, FREE},
		{OP_COMPLETE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, STAT_OK,    54'd0, 22'h000005},
		{OP_COMPLETE, 16'hFFFF, 16'h0000, 16'h0001, 1'b1, STAT_OK,    54'd0, 22'h000005},
		{OP_COMPLETE, 16'hFFFF, 16'h0007, 16'h0001, 1'b1, STAT_NONE,  54'd0, 22'h000005},
		{OP_COMPLETE, 16'h0000, 16'h0001, 16'h0001, 1'b1, STAT_NONE,  54'd0, 22'h000005},
		{OP_COMPLETE, 16'hFFFF, 16'h0001, 16'h0003, 1'b1, STAT_OK,    54'd0, 22'h000002},
		{OP_COMPLETE, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, STAT_OK,    54'd0, 22'h000000},
		{OP_REQUEST,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STAT_NONE,  54'd0, 22'h000000},
		{OP_LOAD,     16'hFFFF, 16'h0002, 16'h0000, 1'b0, FREE},
		{OP_REQUEST,  16'h0000, 16'h0000, 16'h0004, 1'b0, FREE},
		{OP_CLEAR,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STAT_OK,    54'd0, 22'h000000},
		{OP_LOAD,     16'h0000, 16'h0000, 16'h0001, 1'b1, STAT_OK,    54'd0, 22'h000001},
		{OP_LOAD,     16'h0000, 16'hAAAA, 16'h5555, 1'b0, FREE},
		{OP_REQUEST,  16'h5555, 16'hAAAA, 16'h5555, 1'b0, FREE},
		{OP_COMPLETE, 16'h0000, 16'h0000, 16'h0001, 1'b0, FREE},
		{OP_REQUEST,  16'h0000, 16'h0000, 16'hAAAA, 1'b0, FREE},
		{OP_REQUEST,  16'h0000, 16'h0000, 16'h0002, 1'b0, FREE},
		{OP_CLEAR,    16'h0000, 16'h0000, 16'h0000, 1'b0, FREE}
	};

	run_quota_dispatch_table #(
		.SLOTS(SLOT_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rsp_t dispatch_step(cmd_t c);
		rsp_t r;
		int pick;
		int take;
		r = '0;
		pick = -1;
		case (c.operation)
		OP_CLEAR: begin
			tbl_count = 0;
			rr_ptr = 0;
			owed_sum = 0;
			lead_set = 1'b0;
			r.status = STAT_OK;
		end
		OP_LOAD: begin
			if (lead_set && c.gen_id != lead_gen) begin
				r.status = STAT_MIXED;
			end else if (tbl_count >= SLOT_COUNT) begin
				r.status = STAT_FULL;
			end else begin
				if (!lead_set) begin
					lead_gen = c.gen_id;
					lead_set = 1'b1;
				end
				tbl_gen[tbl_count] = c.gen_id;
				tbl_batch[tbl_count] = c.batch_id;
				tbl_owed[tbl_count] = c.run_count;
				tbl_count++;
				owed_sum = owed_sum + int'(c.run_count);
				if (owed_sum > int'(TOTAL_MAX))
					owed_sum = int'(TOTAL_MAX);
				r.status = STAT_OK;
			end
		end
		OP_REQUEST: begin
			if (tbl_count != 0) begin
				if (rr_ptr < tbl_count && tbl_owed[rr_ptr] != 0) begin
					pick = rr_ptr;
				end else begin
					for (int i = 0; i < tbl_count; i++)
						if (pick < 0 && tbl_owed[i] != 0)
							pick = i;
				end
			end
			if (pick < 0) begin
				r.status = STAT_NONE;
			end else begin
				r.status = STAT_OK;
				r.slot_index = pick[5:0];
				r.out_gen = tbl_gen[pick];
				r.out_batch = tbl_batch[pick];
				r.granted_runs = c.run_count;
				rr_ptr = (rr_ptr + 1) % tbl_count;
			end
		end
		default: begin
			for (int i = 0; i < tbl_count; i++)
				if (pick < 0 && tbl_gen[i] == c.gen_id && tbl_batch[i] == c.batch_id)
					pick = i;
			if (pick < 0) begin
				r.status = STAT_NONE;
			end else begin
				take = (c.run_count > tbl_owed[pick]) ? int'(tbl_owed[pick]) :
					int'(c.run_count);
				tbl_owed[pick] = 16'(int'(tbl_owed[pick]) - take);
				owed_sum = (owed_sum > take) ? owed_sum - take : 0;
				r.status = STAT_OK;
			end
		end
		endcase
		r.runs_left_total = owed_sum[TOTAL_W-1:0];
		return r;
	endfunction

	function automatic logic [15:0] pick_runs();
		int roll;
		roll = $urandom_range(0, 5);
		if (roll == 0)
			return 16'h0000;
		else if (roll == 1)
			return 16'hFFFF;
		else if (roll == 2)
			return 16'($urandom_range(1, 15));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic cmd_t noise_cmd(logic [1:0] op);
		cmd_t c;
		c.operation = op;
		c.gen_id = 16'($urandom_range(0, 65535));
		c.batch_id = 16'($urandom_range(0, 65535));
		c.run_count = 16'($urandom_range(0, 65535));
		return c;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Enter and leave at a falling edge; hold the command until the transfer.
	task automatic drive_cmd(input cmd_t c);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		items_sent++;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				predicted = dispatch_step(cmd);
				rsp_due.push_back(pin_next ? pinned_rsp : predicted);
			end
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (rsp.status == STAT_FULL)
					n_full++;
				if (rsp.status == STAT_MIXED)
					n_mixed++;
				if (rsp.status == STAT_NONE)
					n_none++;
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %p", $time, rsp);
					errors++;
				end else begin
					want_rsp = rsp_due.pop_front();
					check_field("status", 32'(want_rsp.status), 32'(rsp.status));
					check_field("slot_index", 32'(want_rsp.slot_index),
						32'(rsp.slot_index));
					check_field("out_gen", 32'(want_rsp.out_gen), 32'(rsp.out_gen));
					check_field("out_batch", 32'(want_rsp.out_batch), 32'(rsp.out_batch));
					check_field("granted_runs", 32'(want_rsp.granted_runs),
						32'(rsp.granted_runs));
					check_field("runs_left_total", 32'(want_rsp.runs_left_total),
						32'(rsp.runs_left_total));
				end
			end
		end
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		while (idle_cycles < WATCHDOG)
			@(negedge clk);
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
		$display("status: fail");
		$finish;
	end

	initial begin
		cmd_t c;
		int n_loads;
		int n_ops;
		int slot;
		int roll;
		int phase_end;
		logic [15:0] ep_gen;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			pin_next = plan[row].pinned;
			pinned_rsp = plan[row].want;
			drive_cmd(plan[row].c);
		end
		pin_next = 1'b0;
		for (int phase = 0; phase < 3; phase++) begin
			snd_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 59 : 0;
			rsp_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 21 : 0;
			// hold off until every outstanding response has drained
			cmd_valid <= 1'b0;
			do @(negedge clk); while (rsp_due.size() != 0);
			phase_end = ITEM_TARGET * (phase + 1) / 3;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 4) != 0)
					drive_cmd(noise_cmd(OP_CLEAR));
				roll = $urandom_range(0, 3);
				if (lead_set)
					ep_gen = lead_gen;
				else if (roll == 0)
					ep_gen = 16'h0000;
				else if (roll == 1)
					ep_gen = 16'hFFFF;
				else
					ep_gen = 16'($urandom_range(0, 65535));
				// now and then overfill the table
				if ($urandom_range(0, 9) == 0)
					n_loads = SLOT_COUNT + $urandom_range(1, 4);
				else
					n_loads = $urandom_range(1, 8);
				for (int k = 0; k < n_loads; k++) begin
					c = noise_cmd(OP_LOAD);
					if (lead_set && $urandom_range(0, 19) == 0)
						c.gen_id = 16'(ep_gen + $urandom_range(1, 65535));
					else
						c.gen_id = ep_gen;
					if ($urandom_range(0, 1) == 0)
						c.batch_id = 16'($urandom_range(0, 7));
					c.run_count = pick_runs();
					drive_cmd(c);
				end
				n_ops = $urandom_range(4, 24);
				for (int k = 0; k < n_ops; k++) begin
					roll = $urandom_range(0, 19);
					if (roll == 0) begin
						c = noise_cmd(2'($urandom_range(0, 3)));
					end else if (roll <= 2 || (roll <= 10 && tbl_count == 0)) begin
						c = noise_cmd(OP_COMPLETE);
					end else if (roll <= 10) begin
						slot = $urandom_range(0, tbl_count - 1);
						c = noise_cmd(OP_COMPLETE);
						c.gen_id = tbl_gen[slot];
						c.batch_id = tbl_batch[slot];
						c.run_count = pick_runs();
					end else begin
						c = noise_cmd(OP_REQUEST);
						c.run_count = pick_runs();
					end
					drive_cmd(c);
				end
			end
		end
		cmd_valid <= 1'b0;
		do @(negedge clk); while (rsp_due.size() != 0);
		repeat (80) @(negedge clk);
		$display("Ran %0d commands (directed table, then random load/request/complete runs)",
			items_sent);
		$display("and checked %0d responses: %0d full, %0d mixed-generation, %0d none.",
			rsp_seen, n_full, n_mixed, n_none);
		if (errors == 0 && rsp_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ run_quota_dispatch_table.f @@
rtl/rqdt_pkg.sv
rtl/rqdt_slot_ram.sv
rtl/run_quota_dispatch_table.sv
test/run_quota_dispatch_table_tb.sv
